// ===== design/bbms_pkg.sv =====
// ----------------------------------------------------------------------------
// bbms_pkg
// Types and constants shared by the bouncing box motion step core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbms_pkg;

   localparam int unsigned Q_WIDTH     = 24;
   localparam int unsigned COEF_WIDTH  = 16;
   localparam int unsigned SIZE_WIDTH  = 12;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [COEF_WIDTH-1:0] GROUND_FRICTION  = 16'd62259;
   localparam logic signed [Q_WIDTH-1:0] BOUNCE_THRESHOLD = 24'sd128;

   localparam logic [COEF_WIDTH-1:0] RST_GRAVITY_STEP   = 16'd128;
   localparam logic [COEF_WIDTH-1:0] RST_BOUNCE_DAMPING = 16'd58982;
   localparam logic [COEF_WIDTH-1:0] RST_AIR_DRAG       = 16'd65208;
   localparam logic [SIZE_WIDTH-1:0] RST_AREA_WIDTH     = 12'd640;
   localparam logic [SIZE_WIDTH-1:0] RST_AREA_HEIGHT    = 12'd480;
   localparam logic [SIZE_WIDTH-1:0] RST_BOX_WIDTH      = 12'd100;
   localparam logic [SIZE_WIDTH-1:0] RST_BOX_HEIGHT     = 12'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRAVITY_STEP   = 3'd0,
      CSR_BOUNCE_DAMPING = 3'd1,
      CSR_AIR_DRAG       = 3'd2,
      CSR_AREA_WIDTH     = 3'd3,
      CSR_AREA_HEIGHT    = 3'd4,
      CSR_BOX_WIDTH      = 3'd5,
      CSR_BOX_HEIGHT     = 3'd6
   } bbms_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAG,
      ST_MOVE,
      ST_WALL,
      ST_FLOOR,
      ST_CEIL,
      ST_HOLD
   } bbms_state_type;

   typedef struct packed {
      logic wall;
      logic floor_hit;
      logic ceil_hit;
   } bbms_hit_type;

endpackage

// ===== design/bouncing_box_motion_step_core.sv =====
// ----------------------------------------------------------------------------
// bouncing_box_motion_step_core
// Position and velocity of one box under gravity, drag and wall bounces.
// Tick beat: steps through DRAG, MOVE, WALL, FLOOR and CEIL, then holds the result
// in HOLD; the next beat is accepted in the cycle after the result is taken. The
// shared 25x17 multiplier runs the drag, wall, floor and ceiling products in the
// DRAG, WALL, FLOOR and CEIL states. Load beat: result valid in the cycle after
// accept. Reset zeroes the box state and restores the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bouncing_box_motion_step_core
   import bbms_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic signed [Q_WIDTH-1:0]    req_load_pos_x,
   input  logic signed [Q_WIDTH-1:0]    req_load_pos_y,
   input  logic signed [Q_WIDTH-1:0]    req_load_vel_x,
   input  logic signed [Q_WIDTH-1:0]    req_load_vel_y,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [Q_WIDTH-1:0]    rsp_pos_x_now,
   output logic signed [Q_WIDTH-1:0]    rsp_pos_y_now,
   output logic signed [Q_WIDTH-1:0]    rsp_vel_x_now,
   output logic signed [Q_WIDTH-1:0]    rsp_vel_y_now,
   output logic                         rsp_bounced,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   bbms_state_type             state_ff, state_in;
   logic signed [Q_WIDTH-1:0]  pos_x_ff, pos_x_in;
   logic signed [Q_WIDTH-1:0]  pos_y_ff, pos_y_in;
   logic signed [Q_WIDTH-1:0]  vel_x_ff, vel_x_in;
   logic signed [Q_WIDTH-1:0]  vel_y_ff, vel_y_in;
   bbms_hit_type               hit_ff, hit_in;
   logic                       bounced_ff, bounced_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [COEF_WIDTH-1:0]      gravity_ff;
   logic [COEF_WIDTH-1:0]      damping_ff;
   logic [COEF_WIDTH-1:0]      drag_ff;
   logic [SIZE_WIDTH-1:0]      area_w_ff;
   logic [SIZE_WIDTH-1:0]      area_h_ff;
   logic [SIZE_WIDTH-1:0]      box_w_ff;
   logic [SIZE_WIDTH-1:0]      box_h_ff;

   logic signed [Q_WIDTH:0]              mul_a;
   logic        [COEF_WIDTH-1:0]         mul_c;
   logic signed [Q_WIDTH+COEF_WIDTH+1:0] mul_p;
   logic signed [Q_WIDTH-1:0]            mul_q;

   logic signed [Q_WIDTH:0]    grav_sum;
   logic signed [Q_WIDTH-1:0]  vy_sat;
   logic signed [SIZE_WIDTH:0] span_x;
   logic signed [SIZE_WIDTH:0] span_y;
   logic signed [Q_WIDTH:0]    rmax;
   logic signed [Q_WIDTH:0]    bmax;
   logic signed [Q_WIDTH:0]    sum_x;
   logic signed [Q_WIDTH:0]    sum_y;
   logic                       hit_left;
   logic                       hit_right;
   logic                       floor_fast;
   logic                       req_fire;
   logic                       rsp_fire;

   assign req_stall     = (state_ff != ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x_now = pos_x_ff;
   assign rsp_pos_y_now = pos_y_ff;
   assign rsp_vel_x_now = vel_x_ff;
   assign rsp_vel_y_now = vel_y_ff;
   assign rsp_bounced   = bounced_ff;

   assign req_fire = req_valid & ~req_stall;
   assign rsp_fire = rsp_valid_ff & ~rsp_stall;

   // shared multiplier: floor(a * c / 2^16)
   assign mul_p = mul_a * $signed({2'b00, mul_c});
   assign mul_q = mul_p[Q_WIDTH+COEF_WIDTH-1:COEF_WIDTH];

   assign floor_fast = (vel_y_ff > BOUNCE_THRESHOLD);

   always_comb begin
      mul_a = {vel_x_ff[Q_WIDTH-1], vel_x_ff};
      mul_c = drag_ff;
      case (state_ff)
         ST_WALL: begin
            mul_a = -{vel_x_ff[Q_WIDTH-1], vel_x_ff};
            mul_c = damping_ff;
         end
         ST_FLOOR: begin
            if (floor_fast) begin
               mul_a = -{vel_y_ff[Q_WIDTH-1], vel_y_ff};
               mul_c = damping_ff;
            end else begin
               mul_c = GROUND_FRICTION;
            end
         end
         ST_CEIL: begin
            mul_a = -{vel_y_ff[Q_WIDTH-1], vel_y_ff};
            mul_c = damping_ff;
         end
         default: begin
         end
      endcase
   end

   assign grav_sum = {vel_y_ff[Q_WIDTH-1], vel_y_ff} + $signed({9'd0, gravity_ff});
   assign vy_sat   = (grav_sum[Q_WIDTH:Q_WIDTH-1] == 2'b01) ?
                     {1'b0, {(Q_WIDTH-1){1'b1}}} : grav_sum[Q_WIDTH-1:0];

   assign span_x = $signed({1'b0, area_w_ff}) - $signed({1'b0, box_w_ff});
   assign span_y = $signed({1'b0, area_h_ff}) - $signed({1'b0, box_h_ff});
   assign rmax   = {{(Q_WIDTH-SIZE_WIDTH-8){span_x[SIZE_WIDTH]}}, span_x, 8'd0};
   assign bmax   = {{(Q_WIDTH-SIZE_WIDTH-8){span_y[SIZE_WIDTH]}}, span_y, 8'd0};

   assign sum_x = {pos_x_ff[Q_WIDTH-1], pos_x_ff} + {vel_x_ff[Q_WIDTH-1], vel_x_ff};
   assign sum_y = {pos_y_ff[Q_WIDTH-1], pos_y_ff} + {vel_y_ff[Q_WIDTH-1], vel_y_ff};
   assign hit_left  = (sum_x <= 0);
   assign hit_right = (sum_x >= rmax);

   always_comb begin
      state_in     = state_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      vel_x_in     = vel_x_ff;
      vel_y_in     = vel_y_ff;
      hit_in       = hit_ff;
      bounced_in   = bounced_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               bounced_in = 1'b0;
               if (req_command) begin
                  pos_x_in     = req_load_pos_x;
                  pos_y_in     = req_load_pos_y;
                  vel_x_in     = req_load_vel_x;
                  vel_y_in     = req_load_vel_y;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_HOLD;
               end else begin
                  state_in = ST_DRAG;
               end
            end
         end
         ST_DRAG: begin
            vel_x_in = mul_q;
            vel_y_in = vy_sat;
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            if (hit_right) begin
               pos_x_in = rmax[Q_WIDTH-1:0];
            end else if (hit_left) begin
               pos_x_in = '0;
            end else begin
               pos_x_in = sum_x[Q_WIDTH-1:0];
            end
            if (sum_y <= 0) begin
               pos_y_in = '0;
            end else if (sum_y >= bmax) begin
               pos_y_in = bmax[Q_WIDTH-1:0];
            end else begin
               pos_y_in = sum_y[Q_WIDTH-1:0];
            end
            hit_in.wall      = hit_left | hit_right;
            hit_in.floor_hit = (sum_y >= bmax);
            hit_in.ceil_hit  = (sum_y <= 0);
            state_in = ST_WALL;
         end
         ST_WALL: begin
            if (hit_ff.wall) begin
               vel_x_in   = mul_q;
               bounced_in = 1'b1;
            end
            state_in = ST_FLOOR;
         end
         ST_FLOOR: begin
            if (hit_ff.floor_hit) begin
               if (floor_fast) begin
                  vel_y_in   = mul_q;
                  bounced_in = 1'b1;
               end else begin
                  vel_x_in = mul_q;
                  vel_y_in = '0;
               end
            end
            state_in = ST_CEIL;
         end
         ST_CEIL: begin
            if (hit_ff.ceil_hit) begin
               vel_y_in   = mul_q;
               bounced_in = 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         hit_ff       <= '0;
         bounced_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
         hit_ff       <= hit_in;
         bounced_ff   <= bounced_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= RST_GRAVITY_STEP;
         damping_ff <= RST_BOUNCE_DAMPING;
         drag_ff    <= RST_AIR_DRAG;
         area_w_ff  <= RST_AREA_WIDTH;
         area_h_ff  <= RST_AREA_HEIGHT;
         box_w_ff   <= RST_BOX_WIDTH;
         box_h_ff   <= RST_BOX_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GRAVITY_STEP:   gravity_ff <= csr_data;
            CSR_BOUNCE_DAMPING: damping_ff <= csr_data;
            CSR_AIR_DRAG:       drag_ff    <= csr_data;
            CSR_AREA_WIDTH:     area_w_ff  <= csr_data[SIZE_WIDTH-1:0];
            CSR_AREA_HEIGHT:    area_h_ff  <= csr_data[SIZE_WIDTH-1:0];
            CSR_BOX_WIDTH:      box_w_ff   <= csr_data[SIZE_WIDTH-1:0];
            CSR_BOX_HEIGHT:     box_h_ff   <= csr_data[SIZE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== tb/bouncing_box_motion_step_core_tb.sv =====
// ----------------------------------------------------------------------------
// bouncing_box_motion_step_core_tb
// Self-checking bench for the box motion step core. A directed plan covers
// reset, load extremes, wall, floor and ceiling hits, and oversized and empty
// areas under extreme coefficient settings. Random load-then-tick sequences
// follow under several register settings and under sender gaps and receiver
// stalls. Every result beat is checked field by field against a fixed-point
// model of the box in this bench, or against the want of a directed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bouncing_box_motion_step_core_tb;
   import bbms_pkg::*;

   localparam int HALF_PERIOD = 5;
   localparam int unsigned PRESET_RESET    = 0;
   localparam int unsigned PRESET_OVERSIZE = 1;
   localparam int unsigned PRESET_ZERO     = 2;
   localparam int unsigned PRESET_COEF_MAX = 3;
   localparam int unsigned PRESET_COEF_MIN = 4;
   localparam int unsigned HALF_ITEMS      = 100;

   typedef logic signed [Q_WIDTH-1:0] q16_8_type;

   typedef struct packed {
      logic signed [Q_WIDTH-1:0] pos_x;
      logic signed [Q_WIDTH-1:0] pos_y;
      logic signed [Q_WIDTH-1:0] vel_x;
      logic signed [Q_WIDTH-1:0] vel_y;
      logic                      bounced;
   } box_motion_type;

   typedef struct packed {
      logic [COEF_WIDTH-1:0] gravity;
      logic [COEF_WIDTH-1:0] damping;
      logic [COEF_WIDTH-1:0] drag;
      logic [SIZE_WIDTH-1:0] area_w;
      logic [SIZE_WIDTH-1:0] area_h;
      logic [SIZE_WIDTH-1:0] box_w;
      logic [SIZE_WIDTH-1:0] box_h;
   } box_cfg_type;

   typedef struct {
      int unsigned    preset_sel;
      logic           cmd;
      q16_8_type      px;
      q16_8_type      py;
      q16_8_type      vx;
      q16_8_type      vy;
      logic           typed;
      box_motion_type want;
   } step_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_command;
   q16_8_type             req_load_pos_x;
   q16_8_type             req_load_pos_y;
   q16_8_type             req_load_vel_x;
   q16_8_type             req_load_vel_y;
   logic                  rsp_valid;
   logic                  rsp_stall;
   q16_8_type             rsp_pos_x_now;
   q16_8_type             rsp_pos_y_now;
   q16_8_type             rsp_vel_x_now;
   q16_8_type             rsp_vel_y_now;
   logic                  rsp_bounced;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   box_cfg_type    cfg;
   q16_8_type      box_x;
   q16_8_type      box_y;
   q16_8_type      box_vx;
   q16_8_type      box_vy;
   box_motion_type pending_motion[$];
   int unsigned    mismatch_count;
   int unsigned    gap_pct;
   int unsigned    stall_pct;

   bouncing_box_motion_step_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_load_pos_x (req_load_pos_x),
      .req_load_pos_y (req_load_pos_y),
      .req_load_vel_x (req_load_vel_x),
      .req_load_vel_y (req_load_vel_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pos_x_now  (rsp_pos_x_now),
      .rsp_pos_y_now  (rsp_pos_y_now),
      .rsp_vel_x_now  (rsp_vel_x_now),
      .rsp_vel_y_now  (rsp_vel_y_now),
      .rsp_bounced    (rsp_bounced),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   function automatic longint floor_scale(longint v, longint c);
      longint p;
      p = v * c;
      return p >>> 16;
   endfunction

   function automatic longint clamp_q(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic longint edge_limit(logic [SIZE_WIDTH-1:0] area,
                                         logic [SIZE_WIDTH-1:0] box);
      return (longint'(area) - longint'(box)) * 256;
   endfunction

   function automatic box_motion_type advance_box(logic cmd, q16_8_type px,
                                                  q16_8_type py, q16_8_type vx,
                                                  q16_8_type vy);
      box_motion_type r;
      longint nvx, nvy, nx, ny, rmax, bmax;
      logic left, right, floor_hit, ceil_hit;
      r.bounced = 1'b0;
      if (cmd) begin
         box_x  = px;
         box_y  = py;
         box_vx = vx;
         box_vy = vy;
      end else begin
         nvy = clamp_q(longint'(box_vy) + longint'(cfg.gravity));
         nvx = floor_scale(longint'(box_vx), longint'(cfg.drag));
         nx = longint'(box_x) + nvx;
         ny = longint'(box_y) + nvy;
         rmax = edge_limit(cfg.area_w, cfg.box_w);
         bmax = edge_limit(cfg.area_h, cfg.box_h);
         right     = nx >= rmax;
         left      = nx <= 0;
         floor_hit = ny >= bmax;
         ceil_hit  = ny <= 0;
         if (left || right) begin
            if (left) nx = 0;
            if (right) nx = rmax;
            nvx = floor_scale(-nvx, longint'(cfg.damping));
            r.bounced = 1'b1;
         end
         if (floor_hit) begin
            ny = bmax;
            if (nvy > longint'(BOUNCE_THRESHOLD)) begin
               nvy = floor_scale(-nvy, longint'(cfg.damping));
               r.bounced = 1'b1;
            end else begin
               nvx = floor_scale(nvx, longint'(GROUND_FRICTION));
               nvy = 0;
            end
         end
         if (ceil_hit) begin
            ny = 0;
            nvy = floor_scale(-nvy, longint'(cfg.damping));
            r.bounced = 1'b1;
         end
         box_x  = Q_WIDTH'(clamp_q(nx));
         box_y  = Q_WIDTH'(clamp_q(ny));
         box_vx = Q_WIDTH'(clamp_q(nvx));
         box_vy = Q_WIDTH'(clamp_q(nvy));
      end
      r.pos_x = box_x;
      r.pos_y = box_y;
      r.vel_x = box_vx;
      r.vel_y = box_vy;
      return r;
   endfunction

   function automatic box_cfg_type preset_cfg(int unsigned sel);
      box_cfg_type c;
      c = '{RST_GRAVITY_STEP, RST_BOUNCE_DAMPING, RST_AIR_DRAG, RST_AREA_WIDTH,
            RST_AREA_HEIGHT, RST_BOX_WIDTH, RST_BOX_HEIGHT};
      case (sel)
         PRESET_OVERSIZE: begin
            c.area_w = 12'd100;
            c.area_h = 12'd100;
            c.box_w  = 12'd300;
            c.box_h  = 12'd300;
         end
         PRESET_ZERO: begin
            c = '{16'hFFFF, 16'd0, 16'd0, 12'd0, 12'd0, 12'd0, 12'd0};
         end
         PRESET_COEF_MAX: begin
            c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 12'd0, 12'd0};
         end
         PRESET_COEF_MIN: begin
            c = '{16'd0, 16'd0, 16'd0, 12'd1, 12'd1, 12'hFFF, 12'hFFF};
         end
         default: begin
         end
      endcase
      return c;
   endfunction

   function automatic box_cfg_type random_cfg();
      box_cfg_type c;
      c.gravity = 16'($urandom_range(0, 1023));
      c.damping = 16'($urandom);
      c.drag    = 16'($urandom_range(60000, 65535));
      c.area_w  = 12'($urandom_range(64, 4095));
      c.area_h  = 12'($urandom_range(64, 4095));
      c.box_w   = 12'($urandom_range(0, c.area_w - 1));
      c.box_h   = 12'($urandom_range(0, c.area_h - 1));
      return c;
   endfunction

   function automatic q16_8_type any_q();
      return Q_WIDTH'($urandom);
   endfunction

   function automatic q16_8_type pick_within(logic [SIZE_WIDTH-1:0] area,
                                             logic [SIZE_WIDTH-1:0] box);
      longint span;
      span = edge_limit(area, box);
      if (span < 0) span = 0;
      return Q_WIDTH'(longint'($urandom_range(0, int'(span) + 2048)) - 1024);
   endfunction

   function automatic step_row_type mk_row(int unsigned sel, logic cmd, q16_8_type px,
                                           q16_8_type py, q16_8_type vx,
                                           q16_8_type vy);
      step_row_type r;
      r.preset_sel = sel;
      r.cmd        = cmd;
      r.px         = px;
      r.py         = py;
      r.vx         = vx;
      r.vy         = vy;
      r.typed      = cmd;
      r.want       = '{px, py, vx, vy, 1'b0};
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic write_reg(bbms_csr_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_cfg(box_cfg_type c);
      write_reg(CSR_GRAVITY_STEP, c.gravity);
      write_reg(CSR_BOUNCE_DAMPING, c.damping);
      write_reg(CSR_AIR_DRAG, c.drag);
      write_reg(CSR_AREA_WIDTH, CSR_DATA_W'(c.area_w));
      write_reg(CSR_AREA_HEIGHT, CSR_DATA_W'(c.area_h));
      write_reg(CSR_BOX_WIDTH, CSR_DATA_W'(c.box_w));
      write_reg(CSR_BOX_HEIGHT, CSR_DATA_W'(c.box_h));
      @(negedge clock);
      csr_valid = 1'b0;
      cfg = c;
   endtask

   task automatic send_beat(logic cmd, q16_8_type px, q16_8_type py, q16_8_type vx,
                            q16_8_type vy, logic typed, box_motion_type want);
      box_motion_type due;
      @(negedge clock);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_command    = cmd;
      req_load_pos_x = px;
      req_load_pos_y = py;
      req_load_vel_x = vx;
      req_load_vel_y = vy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due = advance_box(cmd, px, py, vx, vy);
      if (typed) due = want;
      pending_motion = {pending_motion, due};
   endtask

   task automatic drain_all();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_motion.size() != 0) @(posedge clock);
   endtask

   // drive stall between edges so it is stable at every sampling edge
   always @(negedge clock) begin
      rsp_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      box_motion_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_motion.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = pending_motion.pop_front();
            if (rsp_pos_x_now !== want.pos_x)
               report_mismatch($sformatf("pos_x_now got %0d expected %0d",
                                         rsp_pos_x_now, want.pos_x));
            if (rsp_pos_y_now !== want.pos_y)
               report_mismatch($sformatf("pos_y_now got %0d expected %0d",
                                         rsp_pos_y_now, want.pos_y));
            if (rsp_vel_x_now !== want.vel_x)
               report_mismatch($sformatf("vel_x_now got %0d expected %0d",
                                         rsp_vel_x_now, want.vel_x));
            if (rsp_vel_y_now !== want.vel_y)
               report_mismatch($sformatf("vel_y_now got %0d expected %0d",
                                         rsp_vel_y_now, want.vel_y));
            if (rsp_bounced !== want.bounced)
               report_mismatch($sformatf("bounced got %0b expected %0b",
                                         rsp_bounced, want.bounced));
         end
      end
   end

   initial begin
      #(5_000_000);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      step_row_type plan[$];
      int unsigned  cur_set;
      int unsigned  n;
      int unsigned  ticks;
      box_cfg_type  next_cfg;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = 1'b0;
      req_load_pos_x = '0;
      req_load_pos_y = '0;
      req_load_vel_x = '0;
      req_load_vel_y = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_GRAVITY_STEP;
      csr_data       = '0;
      gap_pct        = 0;
      stall_pct      = 0;
      mismatch_count = 0;
      cfg            = preset_cfg(PRESET_RESET);
      box_x          = '0;
      box_y          = '0;
      box_vx         = '0;
      box_vy         = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      plan = {plan, mk_row(PRESET_RESET, 1'b0, any_q(), any_q(), any_q(), any_q())};
      plan[0].typed = 1'b1;
      plan[0].want  = '{24'sd0, 24'sd128, 24'sd0, 24'sd128, 1'b1};
      plan = {plan, mk_row(PRESET_RESET, 1'b1, 24'sh7FFFFF, 24'sh7FFFFF,
                           24'sh7FFFFF, 24'sh7FFFFF)};
      plan = {plan, mk_row(PRESET_RESET, 1'b0, any_q(), any_q(), any_q(), any_q())};
      plan = {plan, mk_row(PRESET_RESET, 1'b1, 24'sh800000, 24'sh800000,
                           24'sh800000, 24'sh800000)};
      plan = {plan, mk_row(PRESET_RESET, 1'b0, any_q(), any_q(), any_q(), any_q())};
      plan = {plan, mk_row(PRESET_RESET, 1'b1, 24'sd25600, 24'sd12800,
                           24'sd768, -24'sd512)};
      plan = {plan, mk_row(PRESET_RESET, 1'b0, any_q(), any_q(), any_q(), any_q())};
      plan = {plan, mk_row(PRESET_RESET, 1'b0, any_q(), any_q(), any_q(), any_q())};
      plan = {plan, mk_row(PRESET_RESET, 1'b1, 24'sd51200, 24'sd97224,
                           24'sd512, 24'sd0)};
      plan = {plan, mk_row(PRESET_RESET, 1'b0, any_q(), any_q(), any_q(), any_q())};
      plan = {plan, mk_row(PRESET_RESET, 1'b1, 24'sd51200, 24'sd94720,
                           -24'sd300, 24'sd2560)};
      plan = {plan, mk_row(PRESET_RESET, 1'b0, any_q(), any_q(), any_q(), any_q())};
      plan = {plan, mk_row(PRESET_RESET, 1'b1, 24'sd51200, 24'sd256,
                           24'sd100, -24'sd1280)};
      plan = {plan, mk_row(PRESET_RESET, 1'b0, any_q(), any_q(), any_q(), any_q())};
      plan = {plan, mk_row(PRESET_RESET, 1'b1, 24'sd137984, 24'sd25600,
                           24'sd1024, 24'sd0)};
      plan = {plan, mk_row(PRESET_RESET, 1'b0, any_q(), any_q(), any_q(), any_q())};
      plan = {plan, mk_row(PRESET_OVERSIZE, 1'b1, -24'sd1000, -24'sd2000,
                           24'sd100, 24'sd1000)};
      plan = {plan, mk_row(PRESET_OVERSIZE, 1'b0, any_q(), any_q(), any_q(), any_q())};
      plan = {plan, mk_row(PRESET_OVERSIZE, 1'b0, any_q(), any_q(), any_q(), any_q())};
      plan = {plan, mk_row(PRESET_ZERO, 1'b1, 24'sd0, 24'sd0, 24'sd0, 24'sd0)};
      plan = {plan, mk_row(PRESET_ZERO, 1'b0, any_q(), any_q(), any_q(), any_q())};
      plan = {plan, mk_row(PRESET_ZERO, 1'b0, any_q(), any_q(), any_q(), any_q())};
      plan = {plan, mk_row(PRESET_COEF_MAX, 1'b1, 24'sd524288, 24'sd512000,
                           24'sh800000, 24'sh7FFFFF)};
      plan = {plan, mk_row(PRESET_COEF_MAX, 1'b0, any_q(), any_q(), any_q(), any_q())};
      plan = {plan, mk_row(PRESET_COEF_MAX, 1'b0, any_q(), any_q(), any_q(), any_q())};

      cur_set = PRESET_RESET;
      foreach (plan[i]) begin
         if (plan[i].preset_sel != cur_set) begin
            drain_all();
            apply_cfg(preset_cfg(plan[i].preset_sel));
            cur_set = plan[i].preset_sel;
         end
         send_beat(plan[i].cmd, plan[i].px, plan[i].py, plan[i].vx, plan[i].vy,
                   plan[i].typed, plan[i].want);
      end

      for (int k = 0; k < 8; k++) begin
         gap_pct   = (k / 2 == 1) ? 80 : (k / 2 == 3) ? 16 : 0;
         stall_pct = (k / 2 == 2) ? 80 : (k / 2 == 3) ? 16 : 0;
         case (k)
            0: next_cfg = preset_cfg(PRESET_RESET);
            3: next_cfg = preset_cfg(PRESET_COEF_MAX);
            5: next_cfg = preset_cfg(PRESET_COEF_MIN);
            6: next_cfg = preset_cfg(PRESET_OVERSIZE);
            default: next_cfg = random_cfg();
         endcase
         drain_all();
         apply_cfg(next_cfg);
         n = 0;
         while (n < HALF_ITEMS) begin
            if ($urandom_range(39) == 0) drain_all();
            if ($urandom_range(9) == 0) begin
               send_beat(1'($urandom_range(1)), any_q(), any_q(), any_q(), any_q(),
                         1'b0, '0);
               n++;
            end else begin
               if ($urandom_range(9) < 7)
                  send_beat(1'b1, pick_within(cfg.area_w, cfg.box_w),
                            pick_within(cfg.area_h, cfg.box_h),
                            Q_WIDTH'(longint'($urandom_range(16383)) - 8192),
                            Q_WIDTH'(longint'($urandom_range(16383)) - 8192),
                            1'b0, '0);
               else
                  send_beat(1'b1, any_q(), any_q(), any_q(), any_q(), 1'b0, '0);
               ticks = $urandom_range(1, 14);
               repeat (ticks) send_beat(1'b0, any_q(), any_q(), any_q(), any_q(),
                                        1'b0, '0);
               n += ticks + 1;
            end
         end
      end

      drain_all();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
